### rtl/core/sqi_pkg.sv
// Shared codes and item types for the serpentine queue interleaver.
package sqi_pkg;

	// queue count; the four-bit queue fields of the items cover exactly this many
	localparam int QUEUES = 16;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_PULL = 1'b1;

	localparam logic [1:0] ST_PULLED    = 2'd0;
	localparam logic [1:0] ST_PUSH_OK   = 2'd1;
	localparam logic [1:0] ST_PUSH_FULL = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	typedef struct packed {
		logic               kind;
		logic [3:0]         queue_index;
		logic signed [31:0] push_value;
	} sqi_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] pulled_value;
		logic [3:0]         source_queue;
		logic               last_of_run;
	} sqi_result_t;

endpackage

### rtl/core/sqi_store.sv
// Shared value memory: one write port, one read port, registered read data.
module sqi_store #(
	parameter int ENTRIES = 1024,
	parameter int AW      = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/sqi_scan.sv
// Serpentine pick: next non-empty queue from the cursor, reversing at the end.
module sqi_scan #(
	parameter int QUEUES = 16,
	parameter int QW     = 4
) (
	input  logic [QUEUES-1:0] flags,
	input  logic signed [QW:0] cursor,
	input  logic              going_down,
	output logic              found,
	output logic [QW-1:0]     pick,
	output logic              down_next
);

	logic          any_up, any_dn, any_all;
	logic [QW-1:0] lo_up, hi_dn, lo_all, hi_all;

	always_comb begin
		any_up  = 1'b0;
		any_dn  = 1'b0;
		any_all = 1'b0;
		lo_up   = '0;
		hi_dn   = '0;
		lo_all  = '0;
		hi_all  = '0;
		// descending pass: last hit is the lowest index
		for (int i = QUEUES - 1; i >= 0; i--) begin
			if (flags[i]) begin
				lo_all  = QW'(i);
				any_all = 1'b1;
				if (i > int'(cursor)) begin
					lo_up  = QW'(i);
					any_up = 1'b1;
				end
			end
		end
		// ascending pass: last hit is the highest index
		for (int i = 0; i < QUEUES; i++) begin
			if (flags[i]) begin
				hi_all = QW'(i);
				if (i < int'(cursor)) begin
					hi_dn  = QW'(i);
					any_dn = 1'b1;
				end
			end
		end

		found = any_all;
		if (!going_down) begin
			pick      = any_up ? lo_up : hi_all;
			down_next = !any_up;
		end else begin
			pick      = any_dn ? hi_dn : lo_all;
			down_next = any_dn;
		end
	end

endmodule

### rtl/core/serpentine_queue_interleaver.sv
// Serpentine queue interleaver top level: per-queue pointers, control and result stage.
// Accepts one item every clock cycle (busy stays low); each item yields exactly one
// result, strobed on result_valid in the cycle after the item is taken, along with the
// registered read of the shared value memory; queue pointers and fill counts update at
// the accept edge, so a pull right after a push to the same queue sees the new value.
// Results cannot be held off: the receiver must take result whenever result_valid is high.
module serpentine_queue_interleaver
	import sqi_pkg::*;
#(
	parameter int DEPTH  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  sqi_item_t   item,
	output logic        busy,
	output logic        result_valid,
	output sqi_result_t result
);

	localparam int QW      = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam int DW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW      = $clog2(DEPTH + 1);
	localparam int ENTRIES = QUEUES * DEPTH;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int TW      = $clog2(ENTRIES + 1);

	logic [DW-1:0]      head_q [QUEUES];
	logic [CW-1:0]      fill_q [QUEUES];
	logic signed [QW:0] cursor_q;
	logic               down_q;
	logic [TW-1:0]      total_q;

	logic              valid_s1;
	logic [1:0]        status_s1;
	logic [3:0]        src_s1;
	logic              last_s1;

	logic [QUEUES-1:0] flags;
	logic              found;
	logic [QW-1:0]     pick;
	logic              down_next;

	logic              accept;
	logic              is_pull;
	logic [QW-1:0]     push_q;
	logic              push_ok;
	logic [DW:0]       tail_sum;
	logic [DW-1:0]     tail_pos;
	logic              we;
	logic              re;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic [31:0]       rdata;

	always_comb begin
		for (int i = 0; i < QUEUES; i++) begin
			flags[i] = (fill_q[i] != '0);
		end
	end

	sqi_scan #(
		.QUEUES(QUEUES),
		.QW    (QW)
	) u_scan (
		.flags     (flags),
		.cursor    (cursor_q),
		.going_down(down_q),
		.found     (found),
		.pick      (pick),
		.down_next (down_next)
	);

	assign busy    = 1'b0;
	assign accept  = start & ~busy;
	assign is_pull = (item.kind == KIND_PULL);
	assign push_q  = QW'(item.queue_index);
	assign push_ok = (int'(item.queue_index) < QUEUES) && (fill_q[push_q] != CW'(DEPTH));

	// wrap head + fill into the ring; the sum stays below twice the depth
	assign tail_sum = {1'b0, head_q[push_q]} + (DW + 1)'(fill_q[push_q]);
	assign tail_pos = (int'(tail_sum) >= DEPTH) ? DW'(int'(tail_sum) - DEPTH) : DW'(tail_sum);

	assign waddr = AW'(int'(push_q) * DEPTH + int'(tail_pos));
	assign raddr = AW'(int'(pick) * DEPTH + int'(head_q[pick]));
	assign we    = accept & ~is_pull & push_ok;
	assign re    = accept & is_pull & found;

	sqi_store #(
		.ENTRIES(ENTRIES),
		.AW     (AW)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(item.push_value),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUES; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
			cursor_q <= '1;
			down_q   <= 1'b0;
			total_q  <= '0;
		end else if (accept) begin
			if (!is_pull) begin
				if (push_ok) begin
					fill_q[push_q] <= fill_q[push_q] + CW'(1);
					total_q        <= total_q + TW'(1);
				end
			end else if (found) begin
				head_q[pick] <= (int'(head_q[pick]) == DEPTH - 1) ? '0
					: head_q[pick] + DW'(1);
				fill_q[pick] <= fill_q[pick] - CW'(1);
				total_q      <= total_q - TW'(1);
				cursor_q     <= $signed({1'b0, pick});
				down_q       <= down_next;
			end else begin
				// all empty: return to the start, scanning upward
				cursor_q <= '1;
				down_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!is_pull) begin
				status_s1 <= push_ok ? ST_PUSH_OK : ST_PUSH_FULL;
				src_s1    <= '0;
				last_s1   <= 1'b0;
			end else if (found) begin
				status_s1 <= ST_PULLED;
				src_s1    <= 4'(pick);
				last_s1   <= (total_q == TW'(1));
			end else begin
				status_s1 <= ST_EMPTY;
				src_s1    <= '0;
				last_s1   <= 1'b0;
			end
		end
	end

	assign result_valid        = valid_s1;
	assign result.status       = status_s1;
	assign result.pulled_value = (status_s1 == ST_PULLED) ? rdata : '0;
	assign result.source_queue = src_s1;
	assign result.last_of_run  = last_s1;

endmodule

### test/serpentine_queue_interleaver_tb.sv
// Self-checking testbench for the serpentine queue interleaver: predicts every result and compares.
`timescale 1ns / 1ps

module serpentine_queue_interleaver_tb;
	import sqi_pkg::*;

	localparam int IDLE_LIMIT = 400;
	localparam int RANDOM_ITEMS = 950;

	// Tracks queue contents and the serpentine cursor, holds the results still owed.
	class sqi_scoreboard;
		localparam int QN = 16;
		localparam int DP = 64;

		logic [31:0]  store [QN][DP];
		bit [5:0]     head [QN];
		bit [6:0]     fill [QN];
		int           cursor;
		bit           going_down;
		int           total;
		sqi_result_t  owed_results [$];
		int           errors;

		function new();
			for (int q = 0; q < QN; q++) begin
				head[q] = '0;
				fill[q] = '0;
			end
			cursor = -1;
			going_down = 1'b0;
			total = 0;
			errors = 0;
		endfunction

		// First non-empty queue strictly past from, moving by step; -1 if none.
		function int next_filled(int from, int step);
			int i;
			i = from + step;
			while (i >= 0 && i < QN) begin
				if (fill[i] != 0)
					return i;
				i += step;
			end
			return -1;
		endfunction

		function void note_item(sqi_item_t it);
			sqi_result_t r;
			int q;
			int step;
			int pos;
			r = '0;
			if (it.kind == KIND_PUSH) begin
				q = int'(it.queue_index);
				if (q >= QN || fill[q] >= DP) begin
					r.status = ST_PUSH_FULL;
				end else begin
					pos = (int'(head[q]) + int'(fill[q])) % DP;
					store[q][pos] = it.push_value;
					fill[q] = fill[q] + 1;
					total++;
					r.status = ST_PUSH_OK;
				end
			end else begin
				step = going_down ? -1 : 1;
				q = next_filled(cursor, step);
				if (q < 0) begin
					// reverse and sweep again from the far end
					going_down = ~going_down;
					step = -step;
					q = next_filled(step == 1 ? -1 : QN, step);
				end
				if (q < 0) begin
					cursor = -1;
					going_down = 1'b0;
					r.status = ST_EMPTY;
				end else begin
					r.pulled_value = store[q][head[q]];
					head[q] = head[q] + 1;
					fill[q] = fill[q] - 1;
					total--;
					cursor = q;
					r.source_queue = 4'(q);
					r.last_of_run = (total == 0);
					r.status = ST_PULLED;
				end
			end
			owed_results.push_back(r);
		endfunction

		task report(string msg);
			$display("ERROR %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(sqi_result_t got);
			sqi_result_t exp;
			if (owed_results.size() == 0) begin
				report($sformatf("unexpected result status %0d", got.status));
			end else begin
				exp = owed_results.pop_front();
				if (got.status !== exp.status)
					report($sformatf("status %0d, want %0d", got.status, exp.status));
				if (got.pulled_value !== exp.pulled_value)
					report($sformatf("pulled_value %h, want %h",
						got.pulled_value, exp.pulled_value));
				if (got.source_queue !== exp.source_queue)
					report($sformatf("source_queue %0d, want %0d",
						got.source_queue, exp.source_queue));
				if (got.last_of_run !== exp.last_of_run)
					report($sformatf("last_of_run %0d, want %0d",
						got.last_of_run, exp.last_of_run));
			end
		endtask

		function int pending();
			return owed_results.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	sqi_item_t   item;
	logic        busy;
	logic        result_valid;
	sqi_result_t result;

	sqi_scoreboard sb;
	int  items_sent;
	int  idle_cycles;
	bit  no_idle;

	serpentine_queue_interleaver DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result(result);
	end

	// Watchdog: count cycles with no item and no result moving.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL serpentine_queue_interleaver");
				$finish;
			end
		end
	end

	// Entered just after a falling edge; returns just after a falling edge.
	task send_item(sqi_item_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		sb.note_item(it);
		items_sent++;
		@(negedge clk);
	endtask

	task push(int q, logic [31:0] v);
		sqi_item_t it;
		it.kind = KIND_PUSH;
		it.queue_index = 4'(q);
		it.push_value = v;
		send_item(it);
	endtask

	// Ignored fields carry random bits on a pull.
	task pull();
		sqi_item_t it;
		it.kind = KIND_PULL;
		it.queue_index = 4'($urandom);
		it.push_value = $urandom;
		send_item(it);
	endtask

	initial begin
		int n;
		int q;
		int lo;
		int hi;
		sb = new();
		items_sent = 0;
		no_idle = 1'b0;
		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		idle_cycles <= 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty pull, extreme values and queues, sweep reversal
		pull();
		push(0, 32'h8000_0000);
		push(15, 32'h7FFF_FFFF);
		push(0, 32'h0000_0000);
		push(7, 32'hFFFF_FFFF);
		pull();
		pull();
		pull();
		pull();
		pull();
		pull();
		push(15, 32'h0000_0001);
		push(15, 32'h0000_0002);
		push(3, 32'hA5A5_5A5A);
		pull();
		pull();
		pull();
		pull();
		push(8, 32'h1234_5678);
		pull();
		pull();

		while (items_sent < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 3))
				0: begin
					lo = $urandom_range(0, 15);
					hi = $urandom_range(lo, 15);
					n = $urandom_range(10, 40);
					repeat (n) begin
						if ($urandom_range(0, 99) < 55)
							push($urandom_range(lo, hi), $urandom);
						else
							pull();
					end
				end
				1: begin
					// push one queue 60 to 70 times, enough to run it past full unless it began nearly empty
					q = $urandom_range(0, 15);
					repeat ($urandom_range(60, 70)) push(q, $urandom);
				end
				2: begin
					while (sb.total > 0 && items_sent < RANDOM_ITEMS)
						pull();
					repeat ($urandom_range(1, 2)) pull();
				end
				default: begin
					repeat ($urandom_range(5, 20)) push($urandom_range(0, 15), $urandom);
					repeat ($urandom_range(1, 10)) pull();
				end
			endcase
		end

		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS serpentine_queue_interleaver");
		else
			$display("FAIL serpentine_queue_interleaver");
		$finish;
	end

endmodule

### filelist.f
rtl/core/sqi_pkg.sv
rtl/core/sqi_store.sv
rtl/core/sqi_scan.sv
rtl/core/serpentine_queue_interleaver.sv
test/serpentine_queue_interleaver_tb.sv
